[rtl/ectr_pkg.sv]
// Shared types, constants and AES-128 helper functions for the frame decrypt unit.
// No dependencies.
package ectr_pkg;

    localparam int HEADER_BYTES = 17;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;
    localparam logic [7:0] CI_ELL = 8'h8D;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CI   = 2'd1;
    localparam logic [1:0] ST_NO_KEY   = 2'd2;
    localparam logic [1:0] ST_TOO_SHORT = 2'd3;

    localparam logic [1:0] REG_KEY_HIGH    = 2'd0;
    localparam logic [1:0] REG_KEY_LOW     = 2'd1;
    localparam logic [1:0] REG_KEY_PRESENT = 2'd2;

    localparam logic [3:0] LAST_ROUND = 4'd10;
    localparam logic [3:0] DONE_ROUND = 4'd11;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
        logic       xor_en;
        logic       blk;
        logic [3:0] k;
        logic       orphan;
    } ectr_ent_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
        get_byte = v[127 - 8*i -: 8];
    endfunction

    // Next round key from the previous one.
    function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rcon);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
        w0 = rk[127:96] ^ t;
        w1 = rk[95:64] ^ w0;
        w2 = rk[63:32] ^ w1;
        w3 = rk[31:0] ^ w2;
        key_expand = {w0, w1, w2, w3};
    endfunction

    // SubBytes, ShiftRows, MixColumns (skipped on the final round), AddRoundKey.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic fin);
        logic [7:0] t [16];
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        logic [7:0] e;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[j + 4*c] = SBOX[get_byte(s, j + 4*((c + j) % 4))];
            end
        end
        if (!fin) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c];
                a1 = t[4*c + 1];
                a2 = t[4*c + 2];
                a3 = t[4*c + 3];
                e  = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]     = a0 ^ e ^ xt(a0 ^ a1);
                t[4*c + 1] = a1 ^ e ^ xt(a1 ^ a2);
                t[4*c + 2] = a2 ^ e ^ xt(a2 ^ a3);
                t[4*c + 3] = a3 ^ e ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8*i -: 8] = t[i];
        end
        aes_round = r ^ rk;
    endfunction

endpackage

[rtl/ectr_aes.sv]
// Iterative AES-128 encryption core, one round per cycle, round keys made on the fly.
// Holds one finished keystream block until it is taken. Uses ectr_pkg.
module ectr_aes (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [127:0] ctr,
    output logic         busy,
    output logic         res_valid,
    output logic [127:0] res,
    input  logic         res_take
);
    import ectr_pkg::*;

    logic         run_reg, run_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic         rv_reg, rv_next;
    logic [127:0] res_reg, res_next;
    logic [127:0] rk_new;

    assign rk_new = key_expand(rk_reg, rcon_reg);

    always_comb
    begin
        run_next  = run_reg;
        rnd_next  = rnd_reg;
        st_next   = st_reg;
        rk_next   = rk_reg;
        rcon_next = rcon_reg;
        rv_next   = rv_reg && !res_take;
        res_next  = res_reg;
        if (!run_reg) begin
            if (start) begin
                run_next  = 1'b1;
                rnd_next  = 4'd1;
                st_next   = ctr ^ key;
                rk_next   = key;
                rcon_next = 8'h01;
            end
        end else if (rnd_reg != DONE_ROUND) begin
            st_next   = aes_round(st_reg, rk_new, rnd_reg == LAST_ROUND);
            rk_next   = rk_new;
            rcon_next = xt(rcon_reg);
            rnd_next  = rnd_reg + 4'd1;
        end else if (!rv_reg || res_take) begin
            res_next = st_reg;
            rv_next  = 1'b1;
            run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg <= 1'b0;
            rv_reg  <= 1'b0;
            rnd_reg <= '0;
        end else begin
            run_reg <= run_next;
            rv_reg  <= rv_next;
            rnd_reg <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        rk_reg   <= rk_next;
        rcon_reg <= rcon_next;
        res_reg  <= res_next;
    end

    assign busy      = run_reg;
    assign res_valid = rv_reg;
    assign res       = res_reg;
endmodule

[rtl/ectr_front.sv]
// Front end: tracks byte position, gathers the counter block, checks the CI byte,
// classifies each byte and launches keystream requests ahead. Uses ectr_pkg.
module ectr_front #(
    parameter int POSITION_BITS = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                key_present,
    input  logic                q_full,
    output logic                q_push,
    output ectr_pkg::ectr_ent_t q_ent,
    input  logic                eng_busy,
    output logic                eng_start,
    output logic [127:0]        eng_ctr
);
    import ectr_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_HDR = POSITION_BITS'(HEADER_BYTES);
    localparam logic [POSITION_BITS-1:0] POS_CTR_END = POSITION_BITS'(HEADER_BYTES - 1);
    localparam logic [POSITION_BITS-1:0] POS_CI = POSITION_BITS'(10);

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [127:0]             ctr_reg, ctr_next;
    logic                     ci_reg, ci_next;
    logic                     pend_reg, pend_next;

    logic         acc;
    logic         dec;
    logic         blk;
    logic         issue;
    logic [3:0]   k;
    logic         wr_en;
    logic [3:0]   wr_idx;
    logic [127:0] ctr_w;
    logic [1:0]   st;

    assign k     = pos_reg[3:0] - 4'd1;
    assign dec   = (pos_reg >= POS_HDR) && (pos_reg != POS_MAX) && ci_reg;
    assign blk   = dec && (k == 4'd0);
    assign issue = blk || ((pos_reg == POS_CTR_END) && ci_reg);
    assign full  = q_full || (issue && eng_busy);
    assign acc   = push && !full;

    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = '0;
        if (pos_reg >= POSITION_BITS'(2) && pos_reg <= POSITION_BITS'(9)) begin
            wr_en  = 1'b1;
            wr_idx = pos_reg[3:0] - 4'd2;
        end else if (pos_reg == POSITION_BITS'(11)) begin
            wr_en  = 1'b1;
            wr_idx = 4'd8;
        end else if (pos_reg >= POSITION_BITS'(13) && pos_reg <= POS_CTR_END) begin
            wr_en  = 1'b1;
            wr_idx = pos_reg[3:0] - 4'd4;
        end
    end

    always_comb
    begin
        ctr_w = ctr_reg;
        for (int i = 0; i < 16; i++) begin
            if (wr_en && (wr_idx == 4'(i))) begin
                ctr_w[127 - 8*i -: 8] = in_byte;
            end
        end
    end

    always_comb
    begin
        if (pos_reg < POS_CTR_END) begin
            st = ST_TOO_SHORT;
        end else if (!ci_reg) begin
            st = ST_BAD_CI;
        end else if (!key_present) begin
            st = ST_NO_KEY;
        end else begin
            st = ST_OK;
        end
    end

    assign eng_start = acc && issue;
    assign eng_ctr   = blk ? ctr_reg + 128'd1 : ctr_w;

    always_comb
    begin
        pos_next  = pos_reg;
        ctr_next  = ctr_reg;
        ci_next   = ci_reg;
        pend_next = pend_reg;
        if (acc) begin
            ctr_next = blk ? ctr_reg + 128'd1 : ctr_w;
            if (pos_reg == POS_CI) begin
                ci_next = (in_byte == CI_ELL);
            end
            if (issue) begin
                pend_next = 1'b1;
            end else if (blk) begin
                pend_next = 1'b0;
            end
            if (in_last) begin
                pos_next  = '0;
                ctr_next  = '0;
                ci_next   = 1'b0;
                pend_next = 1'b0;
            end else if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // A request launched but never used by this frame leaves a block to discard.
    always_comb
    begin
        q_ent.data   = in_byte;
        q_ent.last   = in_last;
        q_ent.status = in_last ? st : ST_OK;
        q_ent.xor_en = dec && key_present;
        q_ent.blk    = blk;
        q_ent.k      = k;
        q_ent.orphan = in_last && (issue || (pend_reg && !blk));
    end

    assign q_push = acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            ctr_reg  <= '0;
            ci_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            ctr_reg  <= ctr_next;
            ci_reg   <= ci_next;
            pend_reg <= pend_next;
        end
    end
endmodule

[rtl/ectr_fifo.sv]
// Short request queue between front and back ends.
// Uses ectr_pkg for the entry type and depth.
module ectr_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  ectr_pkg::ectr_ent_t wr_ent,
    output logic                full,
    input  logic                rd,
    output ectr_pkg::ectr_ent_t rd_ent,
    output logic                empty
);
    import ectr_pkg::*;

    ectr_ent_t mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg, wp_next;
    logic [FIFO_AW-1:0] rp_reg, rp_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;

    assign full   = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_ent = mem[rp_reg];

    always_comb
    begin
        wp_next  = wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = rd ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (FIFO_AW+1)'(wr) - (FIFO_AW+1)'(rd);
    end

    always_ff @(posedge clk)
    begin
        if (wr) begin
            mem[wp_reg] <= wr_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

[rtl/ectr_back.sv]
// Back end: applies the keystream to queued bytes, discards unused blocks,
// and holds the result request in an output register. Uses ectr_pkg.
module ectr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  ectr_pkg::ectr_ent_t q_ent,
    output logic                q_pop,
    input  logic                res_valid,
    input  logic [127:0]        res,
    output logic                res_take,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          out_byte,
    output logic                out_last,
    output logic [1:0]          status
);
    import ectr_pkg::*;

    logic [127:0] ks_reg, ks_next;
    logic [1:0]   drop_reg, drop_next;
    logic         ov_reg, ov_next;
    logic [7:0]   ob_reg, ob_next;
    logic         ol_reg, ol_next;
    logic [1:0]   os_reg, os_next;

    logic         ks_ok;
    logic         go;
    logic         drop;
    logic [127:0] ks_use;
    logic [7:0]   ks_byte;

    assign ks_ok   = (drop_reg == '0) && res_valid;
    assign go      = !q_empty && (!q_ent.blk || ks_ok) && (!ov_reg || pop);
    assign drop    = res_valid && (drop_reg != '0);
    assign res_take = drop || (go && q_ent.blk);
    assign q_pop   = go;
    assign ks_use  = q_ent.blk ? res : ks_reg;
    assign ks_byte = ks_use[127 - 8*q_ent.k -: 8];

    always_comb
    begin
        ks_next   = (go && q_ent.blk) ? res : ks_reg;
        drop_next = drop_reg - 2'(drop) + 2'(go && q_ent.orphan);
        ov_next   = go || (ov_reg && !pop);
        ob_next   = ob_reg;
        ol_next   = ol_reg;
        os_next   = os_reg;
        if (go) begin
            ob_next = q_ent.data ^ (q_ent.xor_en ? ks_byte : 8'h00);
            ol_next = q_ent.last;
            os_next = q_ent.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            drop_reg <= '0;
            ov_reg   <= 1'b0;
        end else begin
            drop_reg <= drop_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ks_reg <= ks_next;
        ob_reg <= ob_next;
        ol_reg <= ol_next;
        os_reg <= os_next;
    end

    assign empty    = !ov_reg;
    assign out_byte = ob_reg;
    assign out_last = ol_reg;
    assign status   = os_reg;
endmodule

[rtl/ell_aes_ctr_frame_decrypt_unit.sv]
// Accepted bytes pass through the queue and the back-end output register; one byte per
// cycle is sustained while the output is popped. The iterative AES core runs each block
// ahead during the previous 16 payload bytes; the first payload byte of a frame stalls for it.
// Reset (rst_n low, asynchronous) clears key registers, frame state and queues.
// Top level: config registers, front end, queue, AES core, back end. Uses ectr_pkg.
module ell_aes_ctr_frame_decrypt_unit #(
    parameter int POSITION_BITS = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);
    import ectr_pkg::*;

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic         key_present_reg;

    logic         q_full;
    logic         q_empty;
    logic         q_push;
    logic         q_pop;
    ectr_ent_t    q_wr_ent;
    ectr_ent_t    q_rd_ent;
    logic         eng_busy;
    logic         eng_start;
    logic [127:0] eng_ctr;
    logic         res_valid;
    logic [127:0] res;
    logic         res_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_high_reg    <= '0;
            key_low_reg     <= '0;
            key_present_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_KEY_HIGH:    key_high_reg <= cfg_wdata;
                REG_KEY_LOW:     key_low_reg <= cfg_wdata;
                REG_KEY_PRESENT: key_present_reg <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    ectr_front #(.POSITION_BITS(POSITION_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .key_present (key_present_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_ent       (q_wr_ent),
        .eng_busy    (eng_busy),
        .eng_start   (eng_start),
        .eng_ctr     (eng_ctr)
    );

    ectr_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_push),
        .wr_ent (q_wr_ent),
        .full   (q_full),
        .rd     (q_pop),
        .rd_ent (q_rd_ent),
        .empty  (q_empty)
    );

    ectr_aes u_aes (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (eng_start),
        .key       ({key_high_reg, key_low_reg}),
        .ctr       (eng_ctr),
        .busy      (eng_busy),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    ectr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_ent     (q_rd_ent),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .status    (status)
    );
endmodule

[dv/testbench.sv]
// Testbench for ell_aes_ctr_frame_decrypt_unit: feeds radio meter frames and checks
// every output byte, last flag and status against an in-bench AES-128-CTR predictor.
// Depends on ectr_pkg (status and register codes, CI constant, S-box table).
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ectr_pkg::*;

    localparam int POS_BITS = 9;
    localparam int POS_TOP  = (1 << POS_BITS) - 1;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } plain_byte_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [7:0]  in_byte = 0;
    logic        in_last = 0;
    logic        empty;
    logic        pop = 0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [1:0]  status;
    logic        cfg_we = 0;
    logic [1:0]  cfg_addr = 0;
    logic [63:0] cfg_wdata = 0;

    frame_byte_t raw_q[$];
    plain_byte_t plain_q[$];
    int          errors = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    bit          recv_hold = 0;

    // predictor state
    logic [63:0]          key_hi = 0;
    logic [63:0]          key_lo = 0;
    logic                 key_on = 0;
    logic [POS_BITS-1:0]  frame_pos = 0;
    logic [127:0]         ctr_blk = 0;
    logic [127:0]         ks_blk = 0;
    logic                 ci_ok = 0;

    ell_aes_ctr_frame_decrypt_unit i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_byte(in_byte),
        .in_last(in_last), .empty(empty), .pop(pop), .out_byte(out_byte),
        .out_last(out_last), .status(status), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [7:0] gdouble(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] pt);
        logic [7:0] rk [176];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] w [4];
        logic [7:0] rc;
        logic [7:0] f;
        logic [7:0] a0, a1, a2, a3, e;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[127 - 8*i -: 8];
        end
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
            begin
                w[j] = rk[i - 4 + j];
            end
            if (i % 16 == 0)
            begin
                f    = w[0];
                w[0] = SBOX[w[1]] ^ rc;
                w[1] = SBOX[w[2]];
                w[2] = SBOX[w[3]];
                w[3] = SBOX[f];
                rc   = gdouble(rc);
            end
            for (int j = 0; j < 4; j++)
            begin
                rk[i + j] = rk[i - 16 + j] ^ w[j];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            s[i] = pt[127 - 8*i -: 8] ^ rk[i];
        end
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    t[j + 4*c] = SBOX[s[j + 4*((c + j) % 4)]];
                end
            end
            if (r < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c];
                    a1 = t[4*c + 1];
                    a2 = t[4*c + 2];
                    a3 = t[4*c + 3];
                    e  = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]     = a0 ^ e ^ gdouble(a0 ^ a1);
                    t[4*c + 1] = a1 ^ e ^ gdouble(a1 ^ a2);
                    t[4*c + 2] = a2 ^ e ^ gdouble(a2 ^ a3);
                    t[4*c + 3] = a3 ^ e ^ gdouble(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
            begin
                s[i] = t[i] ^ rk[16*r + i];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            res[127 - 8*i -: 8] = s[i];
        end
        return res;
    endfunction

    task automatic decrypt_byte(input frame_byte_t fb);
        int          p;
        int          k;
        plain_byte_t pb;
        p         = frame_pos;
        pb.data   = fb.data;
        pb.last   = fb.last;
        pb.status = ST_OK;
        if (p >= 2 && p <= 9)
            ctr_blk[127 - 8*(p - 2) -: 8] = fb.data;
        else if (p == 11)
            ctr_blk[127 - 64 -: 8] = fb.data;
        else if (p >= 13 && p <= 16)
            ctr_blk[127 - 8*(p - 4) -: 8] = fb.data;
        if (p == 10)
            ci_ok = (fb.data == CI_ELL);
        if (p >= HEADER_BYTES && p < POS_TOP && ci_ok)
        begin
            k = (p - HEADER_BYTES) % 16;
            if (k == 0)
            begin
                ks_blk  = aes_encrypt({key_hi, key_lo}, ctr_blk);
                ctr_blk = ctr_blk + 128'd1;
            end
            if (key_on)
                pb.data = pb.data ^ ks_blk[127 - 8*k -: 8];
        end
        if (fb.last)
        begin
            if (p < HEADER_BYTES - 1)
                pb.status = ST_TOO_SHORT;
            else if (!ci_ok)
                pb.status = ST_BAD_CI;
            else if (!key_on)
                pb.status = ST_NO_KEY;
            frame_pos = 0;
            ctr_blk   = 0;
            ci_ok     = 0;
        end
        else if (p < POS_TOP)
        begin
            frame_pos = frame_pos + 1;
        end
        plain_q.push_back(pb);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 0;
        end
        else
        begin
            if (push && !full)
                decrypt_byte(raw_q.pop_front());
            if (raw_q.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                push    <= 1;
                in_byte <= raw_q[0].data;
                in_last <= raw_q[0].last;
            end
            else
            begin
                push <= 0;
            end
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        plain_byte_t pb;
        if (!rst_n)
        begin
            pop <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (plain_q.size() == 0)
                begin
                    report("unexpected result", out_byte, 0);
                end
                else
                begin
                    pb = plain_q.pop_front();
                    if (out_byte !== pb.data)
                        report("out_byte", out_byte, pb.data);
                    if (out_last !== pb.last)
                        report("out_last", out_last, pb.last);
                    if (status !== pb.status)
                        report("status", status, pb.status);
                end
            end
            pop <= !recv_hold && ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_key(input logic [63:0] hi, input logic [63:0] lo, input logic on);
        @(posedge clk);
        cfg_we    <= 1;
        cfg_addr  <= REG_KEY_HIGH;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_addr  <= REG_KEY_LOW;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_addr  <= REG_KEY_PRESENT;
        cfg_wdata <= {$urandom, 31'h0, on} ;
        @(posedge clk);
        cfg_addr  <= 2'd3;
        cfg_wdata <= {$urandom, $urandom};
        @(posedge clk);
        cfg_we    <= 0;
        key_hi = hi;
        key_lo = lo;
        key_on = on;
    endtask

    task automatic add_frame(input int len, input bit good_ci);
        frame_byte_t fb;
        for (int i = 0; i < len; i++)
        begin
            fb.data = $urandom;
            if (i == 10 && good_ci)
                fb.data = CI_ELL;
            fb.last = (i == len - 1);
            raw_q.push_back(fb);
        end
    endtask

    task automatic drain();
        while (raw_q.size() > 0 || push || plain_q.size() > 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        repeat (10) @(posedge clk);
        rst_n = 1;

        // reset config: no key
        add_frame(1, 0);
        add_frame(16, 1);
        add_frame(17, 0);
        add_frame(17, 1);
        add_frame(40, 1);
        drain();
        write_key(64'h0, 64'h0, 1);
        add_frame(11, 1);
        add_frame(17, 1);
        add_frame(33, 1);
        add_frame(50, 0);
        add_frame(560, 1);
        drain();
        write_key('1, '1, 1);
        add_frame(49, 1);
        add_frame(16, 1);
        add_frame(18, 1);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0: begin send_idle = 30; recv_idle = 86; end
                1: begin send_idle = 86; recv_idle = 30; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            case (ph)
                0: write_key(64'h0, 64'h0, 1);
                1: write_key({$urandom, $urandom}, {$urandom, $urandom}, 0);
                2: write_key('1, '1, 1);
                default: write_key({$urandom, $urandom}, {$urandom, $urandom}, 1);
            endcase
            if (ph == 4)
            begin
                recv_hold = 1;
                fork
                    begin
                        repeat (300) @(negedge clk);
                        recv_hold = 0;
                    end
                join_none
            end
            sent = 0;
            while (sent < 110)
            begin
                int len;
                if ($urandom_range(99) < 85)
                begin
                    len = $urandom_range(17, 70);
                    add_frame(len, 1);
                end
                else
                begin
                    len = $urandom_range(1, 40);
                    add_frame(len, $urandom_range(1));
                end
                sent += len;
            end
            drain();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
